FILE: rtl/core/frustum_cull_test_top_macros.svh
// Assertion macros for the culling block and its checker.
// Both expect clk and rst in scope.
`ifndef FRUSTUM_CULL_TEST_TOP_MACROS_SVH
`define FRUSTUM_CULL_TEST_TOP_MACROS_SVH

// Condition or implication checked at every edge outside reset
`define FCT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// Antecedent now, consequent on the next edge
`define FCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

FILE: rtl/core/fct_pkg.sv
`timescale 1ns / 1ps

package fct_pkg;

  localparam int NUM_PLANES  = 6;
  localparam int FIELD_W     = 16;
  localparam int NORMAL_FRAC = 14;
  localparam int RADIUS_W    = 15;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int PIPE_DEPTH  = 4;

  typedef struct packed {
    logic signed [FIELD_W-1:0] offset;
    logic signed [FIELD_W-1:0] nz;
    logic signed [FIELD_W-1:0] ny;
    logic signed [FIELD_W-1:0] nx;
  } plane_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PLANE_NEAR,
    REG_PLANE_FAR,
    REG_PLANE_BOTTOM,
    REG_PLANE_TOP,
    REG_PLANE_LEFT,
    REG_PLANE_RIGHT
  } cfg_reg_t;

endpackage

FILE: rtl/core/frustum_cull_test_top.sv
`timescale 1ns / 1ps
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------
// cfg      | cfg_we                 | cfg_index, cfg_data (one plane per index)
// in       | in_valid / in_ready    | mode, ax, ay, az, bx, by, bz, sphere_radius
// out      | out_valid / out_ready  | visible
//
// One item per cycle sustained while out_ready holds; out_valid is registered.
// Four registered stages: input, 18 normal x coordinate products, per-plane
// dot sums, then distance, threshold and plane vote into the result register.
// Each stage stalls only when it is full and the one after it cannot take.
// rst (synchronous) empties the pipeline and clears all six planes to zero.

module frustum_cull_test_top
  import fct_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          mode,
  input  logic signed [COORD_BITS-1:0]  ax,
  input  logic signed [COORD_BITS-1:0]  ay,
  input  logic signed [COORD_BITS-1:0]  az,
  input  logic signed [COORD_BITS-1:0]  bx,
  input  logic signed [COORD_BITS-1:0]  by,
  input  logic signed [COORD_BITS-1:0]  bz,
  input  logic [RADIUS_W-1:0]           sphere_radius,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          visible
);

  localparam int PROD_W = FIELD_W + COORD_BITS;
  localparam int DOT_W  = PROD_W + 2;
  localparam int SHR_W  = DOT_W - NORMAL_FRAC;
  localparam int SUM_W  = ((SHR_W > FIELD_W + 1) ? SHR_W : FIELD_W + 1) + 2;

  plane_t planes [NUM_PLANES];

  logic v0, v1, v2, v3;
  logic ready1, ready2, ready3;

  logic                         s0_mode;
  logic signed [COORD_BITS-1:0] s0_a [3];
  logic signed [COORD_BITS-1:0] s0_b [3];
  logic [2:0]                   s0_a_gt;
  logic [RADIUS_W-1:0]          s0_radius;

  logic                     s1_mode;
  logic [RADIUS_W-1:0]      s1_radius;
  logic signed [PROD_W-1:0] s1_prod [NUM_PLANES][3];
  logic signed [PROD_W-1:0] s1_prod_next [NUM_PLANES][3];

  logic                    s2_mode;
  logic [RADIUS_W-1:0]     s2_radius;
  logic signed [DOT_W-1:0] s2_dot [NUM_PLANES];
  logic signed [DOT_W-1:0] s2_dot_next [NUM_PLANES];

  logic s3_visible;
  logic s3_visible_next;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        planes[i] <= '0;
      end
    end else if (cfg_we && cfg_index <= REG_PLANE_RIGHT) begin
      planes[cfg_index] <= plane_t'(cfg_data);
    end
  end

  // pipeline flow
  assign ready3   = !v3 || out_ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = !v0 || ready1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (in_ready) begin
        v0 <= in_valid;
      end
      if (ready1) begin
        v1 <= v0;
      end
      if (ready2) begin
        v2 <= v1;
      end
      if (ready3) begin
        v3 <= v2;
      end
    end
  end

  // stage 0: input register, corner order per axis
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_mode    <= mode;
      s0_a[0]    <= ax;
      s0_a[1]    <= ay;
      s0_a[2]    <= az;
      s0_b[0]    <= bx;
      s0_b[1]    <= by;
      s0_b[2]    <= bz;
      s0_a_gt[0] <= ax > bx;
      s0_a_gt[1] <= ay > by;
      s0_a_gt[2] <= az > bz;
      s0_radius  <= sphere_radius;
    end
  end

  // stage 1: pick the most positive corner per plane (box) and multiply
  always_comb begin
    logic signed [FIELD_W-1:0]    n;
    logic signed [COORD_BITS-1:0] p;
    for (int i = 0; i < NUM_PLANES; i++) begin
      for (int k = 0; k < 3; k++) begin
        case (k)
          0:       n = planes[i].nx;
          1:       n = planes[i].ny;
          default: n = planes[i].nz;
        endcase
        if (!s0_mode) begin
          p = s0_a[k];
        end else if (n[FIELD_W-1]) begin
          p = s0_a_gt[k] ? s0_b[k] : s0_a[k];
        end else begin
          p = s0_a_gt[k] ? s0_a[k] : s0_b[k];
        end
        s1_prod_next[i][k] = PROD_W'(n) * PROD_W'(p);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (v0 && ready1) begin
      s1_mode   <= s0_mode;
      s1_radius <= s0_radius;
      s1_prod   <= s1_prod_next;
    end
  end

  // stage 2: dot product per plane
  always_comb begin
    for (int i = 0; i < NUM_PLANES; i++) begin
      s2_dot_next[i] = DOT_W'(s1_prod[i][0]) + DOT_W'(s1_prod[i][1])
                     + DOT_W'(s1_prod[i][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && ready2) begin
      s2_mode   <= s1_mode;
      s2_radius <= s1_radius;
      s2_dot    <= s2_dot_next;
    end
  end

  // stage 3: floor shift, add offset (and radius for a sphere), sign test
  always_comb begin
    logic signed [SHR_W-1:0] shr;
    logic signed [SUM_W-1:0] plane_dist;
    logic [NUM_PLANES-1:0]   culled;
    for (int i = 0; i < NUM_PLANES; i++) begin
      shr  = s2_dot[i][DOT_W-1:NORMAL_FRAC];
      plane_dist = SUM_W'(shr) + SUM_W'(planes[i].offset)
                 + (s2_mode ? '0 : SUM_W'({1'b0, s2_radius}));
      culled[i] = plane_dist[SUM_W-1];
    end
    s3_visible_next = ~|culled;
  end

  always_ff @(posedge clk) begin
    if (v2 && ready3) begin
      s3_visible <= s3_visible_next;
    end
  end

  assign out_valid = v3;
  assign visible   = s3_visible;

endmodule

FILE: rtl/core/fct_checker.sv
`timescale 1ns / 1ps
`include "frustum_cull_test_top_macros.svh"

module fct_checker
  import fct_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic visible
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 1);

  logic [CNT_W-1:0] pending;
  logic [CNT_W-1:0] pending_next;
  logic             cfg_seen;

  // items accepted but not yet delivered
  assign pending_next = pending + CNT_W'(in_valid && in_ready)
                      - CNT_W'(out_valid && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      pending  <= '0;
      cfg_seen <= 1'b0;
    end else begin
      pending <= pending_next;
      if (cfg_we) begin
        cfg_seen <= 1'b1;
      end
    end
  end

  `FCT_ASSERT(a_no_invented_item, out_valid |-> pending != '0)
  `FCT_ASSERT(a_depth_bound, pending <= CNT_W'(PIPE_DEPTH))
  `FCT_ASSERT(a_full_stall, (pending == CNT_W'(PIPE_DEPTH) && !out_ready) |-> !in_ready)
  `FCT_ASSERT_NEXT(a_result_hold, out_valid && !out_ready, out_valid && $stable(visible))
  `FCT_ASSERT(a_zero_planes_visible, (out_valid && !cfg_seen) |-> visible)

endmodule

bind frustum_cull_test_top fct_checker u_fct_checker (.*);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fct_pkg::*;

  localparam bit MODE_SPHERE = 1'b0;
  localparam bit MODE_BOX    = 1'b1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE_LO = CFG_INDEX_W'(NUM_PLANES);
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE_HI = CFG_INDEX_W'(NUM_PLANES + 1);
  localparam int STALL_LIMIT   = 5000;
  localparam int PHASE_ITEMS   = 170;
  localparam int RANDOM_PHASES = 8;

  typedef enum int {
    SET_CLEAR,
    SET_SLAB,
    SET_EXTREME,
    SET_RANDOM,
    SET_ENCLOSING
  } plane_set_t;

  typedef struct packed {
    logic                      mode;
    logic signed [FIELD_W-1:0] ax;
    logic signed [FIELD_W-1:0] ay;
    logic signed [FIELD_W-1:0] az;
    logic signed [FIELD_W-1:0] bx;
    logic signed [FIELD_W-1:0] by;
    logic signed [FIELD_W-1:0] bz;
    logic [RADIUS_W-1:0]       sphere_radius;
  } volume_t;

  typedef struct {
    plane_set_t set;
    bit         known;
    bit         vis;
    volume_t    vol;
  } probe_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic mode = 1'b0;
  logic signed [FIELD_W-1:0] ax = '0;
  logic signed [FIELD_W-1:0] ay = '0;
  logic signed [FIELD_W-1:0] az = '0;
  logic signed [FIELD_W-1:0] bx = '0;
  logic signed [FIELD_W-1:0] by = '0;
  logic signed [FIELD_W-1:0] bz = '0;
  logic [RADIUS_W-1:0] sphere_radius = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic visible;

  plane_t planes [NUM_PLANES];
  bit visible_due [$];
  probe_t probes [$];
  bit calm = 1'b0;
  bit due_visible;
  int errors = 0;
  int stall_cycles = 0;

  always #6 clk = ~clk;

  frustum_cull_test_top #(
    .COORD_BITS(FIELD_W)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .ax(ax),
    .ay(ay),
    .az(az),
    .bx(bx),
    .by(by),
    .bz(bz),
    .sphere_radius(sphere_radius),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .visible(visible)
  );

  function automatic bit predict_visible(input volume_t v);
    longint a [3];
    longint b [3];
    longint nrm [3];
    longint pick;
    longint dot;
    longint plane_dist;
    a[0] = $signed(v.ax);
    a[1] = $signed(v.ay);
    a[2] = $signed(v.az);
    b[0] = $signed(v.bx);
    b[1] = $signed(v.by);
    b[2] = $signed(v.bz);
    for (int p = 0; p < NUM_PLANES; p++) begin
      nrm[0] = $signed(planes[p].nx);
      nrm[1] = $signed(planes[p].ny);
      nrm[2] = $signed(planes[p].nz);
      dot = 0;
      for (int k = 0; k < 3; k++) begin
        // box: corner furthest along the normal, whichever field holds it
        if (v.mode == MODE_SPHERE) pick = a[k];
        else if ((nrm[k] >= 0) == (a[k] > b[k])) pick = a[k];
        else pick = b[k];
        dot += nrm[k] * pick;
      end
      plane_dist = (dot >>> NORMAL_FRAC) + longint'($signed(planes[p].offset));
      if ((v.mode == MODE_BOX) ? (plane_dist < 0)
                               : (plane_dist < -longint'(v.sphere_radius)))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic plane_t plane_of(input int nx, input int ny, input int nz, input int off);
    plane_t pl;
    pl.nx = FIELD_W'(nx);
    pl.ny = FIELD_W'(ny);
    pl.nz = FIELD_W'(nz);
    pl.offset = FIELD_W'(off);
    return pl;
  endfunction

  function automatic void choose_planes(input plane_set_t s);
    int comp [3];
    int axis;
    case (s)
      SET_CLEAR: begin
        foreach (planes[i]) planes[i] = '0;
      end
      SET_SLAB: begin
        // x and y within +-100, z within 10..1000, normals exactly 1.0
        planes[REG_PLANE_NEAR]   = plane_of(0, 0, 16384, -10);
        planes[REG_PLANE_FAR]    = plane_of(0, 0, -16384, 1000);
        planes[REG_PLANE_BOTTOM] = plane_of(0, 16384, 0, 100);
        planes[REG_PLANE_TOP]    = plane_of(0, -16384, 0, 100);
        planes[REG_PLANE_LEFT]   = plane_of(16384, 0, 0, 100);
        planes[REG_PLANE_RIGHT]  = plane_of(-16384, 0, 0, 100);
      end
      SET_EXTREME: begin
        planes[REG_PLANE_NEAR]   = plane_of(-32768, -32768, -32768, 32767);
        planes[REG_PLANE_FAR]    = plane_of(32767, 32767, 32767, -32768);
        planes[REG_PLANE_BOTTOM] = plane_of(-32768, 32767, 0, 0);
        planes[REG_PLANE_TOP]    = plane_of(32767, -32768, -1, 32767);
        planes[REG_PLANE_LEFT]   = plane_of(-1, -1, -1, -32768);
        planes[REG_PLANE_RIGHT]  = plane_of(0, 0, 0, 32767);
      end
      SET_RANDOM: begin
        foreach (planes[i]) planes[i] = {$urandom, $urandom};
      end
      default: begin
        // tilted planes around the origin, so volumes near it often survive
        for (int i = 0; i < NUM_PLANES; i++) begin
          axis = 2 - i / 2;
          for (int k = 0; k < 3; k++) comp[k] = int'($urandom_range(0, 4000)) - 2000;
          comp[axis] = int'($urandom_range(4096, 32767));
          if (i % 2 == 1) comp[axis] = -comp[axis];
          planes[i] = plane_of(comp[0], comp[1], comp[2], int'($urandom_range(0, 30000)));
        end
      end
    endcase
  endfunction

  function automatic logic signed [FIELD_W-1:0] pick_coord(input bit wide, input int span);
    if (wide) return FIELD_W'($urandom);
    return FIELD_W'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic volume_t random_volume();
    volume_t v;
    bit wide;
    int span;
    wide = ($urandom_range(0, 9) < 3);
    span = int'($urandom_range(1, 20000));
    v.mode = 1'($urandom_range(0, 1));
    v.ax = pick_coord(wide, span);
    v.ay = pick_coord(wide, span);
    v.az = pick_coord(wide, span);
    v.bx = pick_coord(wide, span);
    v.by = pick_coord(wide, span);
    v.bz = pick_coord(wide, span);
    if ($urandom_range(0, 1)) v.sphere_radius = RADIUS_W'($urandom_range(0, 32767));
    else v.sphere_radius = RADIUS_W'($urandom_range(0, 3000));
    return v;
  endfunction

  function automatic void add_probe(input plane_set_t s, input bit known, input bit vis,
                                    input bit m, input int x0, input int y0, input int z0,
                                    input int x1, input int y1, input int z1, input int r);
    probe_t p;
    p.set = s;
    p.known = known;
    p.vis = vis;
    p.vol.mode = m;
    p.vol.ax = FIELD_W'(x0);
    p.vol.ay = FIELD_W'(y0);
    p.vol.az = FIELD_W'(z0);
    p.vol.bx = FIELD_W'(x1);
    p.vol.by = FIELD_W'(y1);
    p.vol.bz = FIELD_W'(z1);
    p.vol.sphere_radius = RADIUS_W'(r);
    probes.push_back(p);
  endfunction

  task automatic send_item(input volume_t v, input bit known, input bit vis);
    while (!calm && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= v.mode;
    ax <= v.ax;
    ay <= v.ay;
    az <= v.az;
    bx <= v.bx;
    by <= v.by;
    bz <= v.bz;
    sphere_radius <= v.sphere_radius;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    visible_due.push_back(known ? vis : predict_visible(v));
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (visible_due.size() != 0) @(posedge clk);
  endtask

  task automatic load_planes(input plane_set_t s);
    settle();
    choose_planes(s);
    for (int i = 0; i < NUM_PLANES; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data <= planes[i];
      @(posedge clk);
    end
    // unused indexes must leave the planes alone
    cfg_index <= CFG_INDEX_SPARE_LO;
    cfg_data <= {$urandom, $urandom};
    @(posedge clk);
    cfg_index <= CFG_INDEX_SPARE_HI;
    cfg_data <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (visible_due.size() == 0) begin
        $display("%0t: result with none due, expected none, got visible=%0b", $time, visible);
        errors++;
      end else begin
        due_visible = visible_due.pop_front();
        if (visible !== due_visible) begin
          $display("%0t: visible mismatch, expected %0b, got %0b", $time, due_visible, visible);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("tb_top: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    plane_set_t cur_set;
    plane_set_t random_sets [RANDOM_PHASES];
    random_sets = '{SET_ENCLOSING, SET_RANDOM, SET_ENCLOSING, SET_EXTREME,
                    SET_ENCLOSING, SET_CLEAR, SET_ENCLOSING, SET_RANDOM};
    cur_set = SET_CLEAR;
    foreach (planes[i]) planes[i] = '0;

    // planes cleared by reset: nothing is culled
    add_probe(SET_CLEAR, 1, 1, MODE_SPHERE, -32768, -32768, -32768, 0, 0, 0, 0);
    add_probe(SET_CLEAR, 1, 1, MODE_BOX, 32767, 32767, 32767, -32768, -32768, -32768, 0);
    add_probe(SET_CLEAR, 1, 1, MODE_SPHERE, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    // slab: x, y in -100..100, z in 10..1000
    add_probe(SET_SLAB, 1, 1, MODE_SPHERE, 0, 0, 500, 0, 0, 0, 0);
    add_probe(SET_SLAB, 1, 1, MODE_SPHERE, 0, 0, 10, 0, 0, 0, 0);
    add_probe(SET_SLAB, 1, 0, MODE_SPHERE, 0, 0, 9, 0, 0, 0, 0);
    add_probe(SET_SLAB, 1, 1, MODE_SPHERE, 0, 0, 9, 0, 0, 0, 1);
    add_probe(SET_SLAB, 1, 0, MODE_SPHERE, 101, 0, 500, 0, 0, 0, 0);
    add_probe(SET_SLAB, 1, 1, MODE_SPHERE, 101, 0, 500, 0, 0, 0, 1);
    add_probe(SET_SLAB, 1, 0, MODE_SPHERE, 0, 0, -32768, 0, 0, 0, 32767);
    add_probe(SET_SLAB, 1, 1, MODE_SPHERE, 0, 0, -32757, 0, 0, 0, 32767);
    add_probe(SET_SLAB, 1, 1, MODE_SPHERE, 0, 0, 500, -32768, -32768, -32768, 0);
    add_probe(SET_SLAB, 1, 1, MODE_BOX, -50, -50, 20, 50, 50, 500, 0);
    add_probe(SET_SLAB, 1, 1, MODE_BOX, 50, 50, 500, -50, -50, 20, 0);
    add_probe(SET_SLAB, 1, 0, MODE_BOX, -200, -50, 20, -150, 50, 500, 32767);
    add_probe(SET_SLAB, 1, 0, MODE_BOX, -150, 50, 500, -200, -50, 20, 0);
    add_probe(SET_SLAB, 1, 1, MODE_BOX, -200, -200, -32768, 32767, 32767, 32767, 0);
    add_probe(SET_SLAB, 1, 1, MODE_BOX, 101, 0, 20, 100, 0, 30, 0);
    add_probe(SET_SLAB, 1, 0, MODE_BOX, 101, 0, 20, 102, 0, 30, 0);
    // extreme normals and offsets
    add_probe(SET_EXTREME, 0, 0, MODE_SPHERE, -32768, -32768, -32768, 0, 0, 0, 32767);
    add_probe(SET_EXTREME, 0, 0, MODE_SPHERE, 32767, 32767, 32767, 0, 0, 0, 0);
    add_probe(SET_EXTREME, 0, 0, MODE_SPHERE, 0, 0, 0, 0, 0, 0, 32767);
    add_probe(SET_EXTREME, 0, 0, MODE_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0);
    add_probe(SET_EXTREME, 0, 0, MODE_BOX, 32767, -32768, 32767, -32768, 32767, -32768, 0);
    add_probe(SET_EXTREME, 0, 0, MODE_BOX, -1, 0, -1, 0, -1, 0, 0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[i]) begin
      if (probes[i].set != cur_set) begin
        load_planes(probes[i].set);
        cur_set = probes[i].set;
      end
      send_item(probes[i].vol, probes[i].known, probes[i].vis);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_planes(random_sets[ph]);
      calm <= (ph == 2);
      repeat (PHASE_ITEMS) send_item(random_volume(), 1'b0, 1'b0);
    end

    settle();
    repeat (PIPE_DEPTH + 4) @(posedge clk);
    if (errors == 0 && visible_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/fct_pkg.sv
rtl/core/frustum_cull_test_top.sv
rtl/core/fct_checker.sv
sim/tb_top.sv
